>>> design/switch_bank_change_event_encoder_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the switch bank change-event encoder
// Concurrent checks that compile away for synthesis.
// ---------------------------------------------------------------------------
`ifndef SWITCH_BANK_CHANGE_EVENT_ENCODER_CORE_DEFINES_SVH
`define SWITCH_BANK_CHANGE_EVENT_ENCODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define SBCE_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);
// Condition must never be true outside reset
`define SBCE_NEVER(lbl, ck, rn, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error(msg);
`else
`define SBCE_ASSERT(lbl, ck, rn, prop, msg)
`define SBCE_NEVER(lbl, ck, rn, cond, msg)
`endif

`endif

>>> design/sbce_pkg.sv
// ---------------------------------------------------------------------------
// sbce_pkg
// Widths, event kinds, encoder pair table and controller/datapath structs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbce_pkg;

  localparam int BANK_W    = 4;
  localparam int VAL_W     = 8;
  localparam int BIT_W     = 3;
  localparam int KIND_W    = 2;
  localparam int ENC_SEL_W = 3;
  localparam int ENC_TABLE = 8;

  localparam int DEF_NUM_BANKS    = 12;
  localparam int DEF_NUM_ENCODERS = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_PRESS = 2'd0,
    KIND_RIGHT = 2'd1,
    KIND_LEFT  = 2'd2
  } kind_t;

  // Encoder pair table: entry is populated for the first six slots
  function automatic logic enc_valid(input logic [ENC_SEL_W-1:0] e);
    return (e < ENC_SEL_W'(6));
  endfunction

  function automatic logic [BANK_W-1:0] enc_bank(input logic [ENC_SEL_W-1:0] e);
    logic [BANK_W-1:0] b;
    case (e)
      3'd0:    b = 4'd2;
      3'd1:    b = 4'd4;
      3'd2:    b = 4'd4;
      3'd3:    b = 4'd6;
      3'd4:    b = 4'd7;
      3'd5:    b = 4'd10;
      default: b = 4'd0;
    endcase
    return b;
  endfunction

  function automatic logic [BIT_W-1:0] enc_low(input logic [ENC_SEL_W-1:0] e);
    logic [BIT_W-1:0] lo;
    case (e)
      3'd0:    lo = 3'd5;
      3'd1:    lo = 3'd4;
      3'd2:    lo = 3'd0;
      3'd3:    lo = 3'd4;
      3'd4:    lo = 3'd4;
      3'd5:    lo = 3'd2;
      default: lo = 3'd0;
    endcase
    return lo;
  endfunction

  // Controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             step;
    logic             flush;
    logic [BIT_W-1:0] bit_idx;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_range;
    logic needs_push;
    logic out_free;
    logic pend_vld;
  } dp_sts_t;

endpackage

>>> design/sbce_ctrl.sv
// ---------------------------------------------------------------------------
// sbce_ctrl
// Sequencer: accepts a scan beat, walks the eight bits, flushes the last event.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "switch_bank_change_event_encoder_core_defines.svh"

module sbce_ctrl
  import sbce_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(VAL_W - 1);

  state_t           state_r, state_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;

  // Decode commands and next state
  always_comb begin
    cmd         = '0;
    cmd.bit_idx = bit_r;
    in_ready    = (state_r == S_IDLE);
    state_nxt   = state_r;
    bit_nxt     = bit_r;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_valid && sts.in_range;
        if (cmd.load) begin
          state_nxt = S_SCAN;
          bit_nxt   = '0;
        end
      end
      S_SCAN: begin
        // stall only when an event must move into a busy output register
        cmd.step = !sts.needs_push || sts.out_free;
        if (cmd.step) begin
          if (bit_r == LAST_BIT) begin
            state_nxt = S_DONE;
          end else begin
            bit_nxt = bit_r + BIT_W'(1);
          end
        end
      end
      S_DONE: begin
        cmd.flush = sts.pend_vld && sts.out_free;
        if (!sts.pend_vld || sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and bit counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      bit_r   <= bit_nxt;
    end
  end

  `SBCE_ASSERT(a_load_starts_scan, clk, rst_n, cmd.load |=> (state_r == S_SCAN && bit_r == '0), "load did not start scan at bit zero")

endmodule

>>> design/sbce_dp.sv
// ---------------------------------------------------------------------------
// sbce_dp
// Bank store, encoder state, one-bit event logic, pending and output registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "switch_bank_change_event_encoder_core_defines.svh"

module sbce_dp
  import sbce_pkg::*;
#(
  parameter int NUM_BANKS    = DEF_NUM_BANKS,
  parameter int NUM_ENCODERS = DEF_NUM_ENCODERS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  input  logic [BANK_W-1:0] in_bank,
  input  logic [VAL_W-1:0]  in_val,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [BANK_W-1:0] out_bank,
  output logic [BIT_W-1:0]  out_bit,
  output kind_t             out_kind,
  output logic              out_last
);

  localparam int BANK_IW = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int ENC_IW  = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;
  localparam logic [BANK_W:0] BANK_LIMIT = (BANK_W + 1)'(NUM_BANKS);

  // Stored state
  logic [VAL_W-1:0] prev_bank_r [NUM_BANKS];
  logic [1:0]       enc_lvl_r   [NUM_ENCODERS];
  logic [1:0]       enc_flg_r   [NUM_ENCODERS];

  // Latched scan beat
  logic [BANK_W-1:0] bank_r;
  logic [VAL_W-1:0]  val_r;
  logic [VAL_W-1:0]  diff_r;

  // Pending event and output register
  logic              pend_vld_r;
  logic [BIT_W-1:0]  pend_bit_r;
  kind_t             pend_kind_r;
  logic              out_vld_r;
  logic [BANK_W-1:0] out_bank_r;
  logic [BIT_W-1:0]  out_bit_r;
  kind_t             out_kind_r;
  logic              out_last_r;

  logic [BANK_IW-1:0] bank_sel;
  logic               in_range;
  logic [BIT_W-1:0]   cur_bit;
  logic               changed;

  logic               enc_hit;
  logic [ENC_IW-1:0]  enc_sel;
  logic [BIT_W-1:0]   enc_lo;
  logic [1:0]         lvl_cur, flg_cur, lvl_new, flg_new;
  logic               h, l, th, tl, rt, lf;
  logic               ev_right, ev_left;

  logic               emit;
  kind_t              new_kind;
  logic [BIT_W-1:0]   new_bit;
  logic               push_step;
  logic               out_free;

  assign bank_sel = in_bank[BANK_IW-1:0];
  assign in_range = ({1'b0, in_bank} < BANK_LIMIT);
  assign cur_bit  = cmd.bit_idx;
  assign changed  = diff_r[cur_bit];

  // Find the encoder pair that owns the current bit, first match wins
  always_comb begin
    enc_hit = 1'b0;
    enc_sel = '0;
    enc_lo  = '0;
    for (int e = 0; e < NUM_ENCODERS; e++) begin
      if (!enc_hit && enc_valid(ENC_SEL_W'(e)) && enc_bank(ENC_SEL_W'(e)) == bank_r &&
          (cur_bit == enc_low(ENC_SEL_W'(e)) ||
           cur_bit == enc_low(ENC_SEL_W'(e)) + BIT_W'(1))) begin
        enc_hit = 1'b1;
        enc_sel = ENC_IW'(e);
        enc_lo  = enc_low(ENC_SEL_W'(e));
      end
    end
  end

  // One quadrature step of the selected encoder
  always_comb begin
    lvl_cur  = enc_lvl_r[enc_sel];
    flg_cur  = enc_flg_r[enc_sel];
    h        = val_r[enc_lo + BIT_W'(1)];
    l        = val_r[enc_lo];
    tl       = lvl_cur[0];
    th       = lvl_cur[1];
    rt       = flg_cur[0];
    lf       = flg_cur[1];
    ev_right = 1'b0;
    ev_left  = 1'b0;
    if (h != l) begin
      if (h != th) begin
        th = h;
        rt = 1'b1;
      end else if (l != tl) begin
        tl = l;
        lf = 1'b1;
      end
    end else if (th != tl && (rt || lf)) begin
      if (rt && th == h) begin
        ev_right = 1'b1;
        tl       = l;
        rt       = 1'b0;
      end else if (lf && tl == l) begin
        ev_left = 1'b1;
        th      = h;
        lf      = 1'b0;
      end else begin
        tl = l;
        th = h;
        rt = 1'b0;
        lf = 1'b0;
      end
    end
    lvl_new = {th, tl};
    flg_new = {lf, rt};
  end

  // Event for the current bit
  always_comb begin
    if (enc_hit) begin
      emit     = changed && (ev_right || ev_left);
      new_kind = ev_right ? KIND_RIGHT : KIND_LEFT;
      new_bit  = ev_right ? enc_lo : enc_lo + BIT_W'(1);
    end else begin
      emit     = changed && !val_r[cur_bit];
      new_kind = KIND_PRESS;
      new_bit  = cur_bit;
    end
  end

  assign out_free  = !out_vld_r || out_ready;
  assign push_step = cmd.step && emit && pend_vld_r;

  assign sts.in_range   = in_range;
  assign sts.needs_push = emit && pend_vld_r;
  assign sts.out_free   = out_free;
  assign sts.pend_vld   = pend_vld_r;

  // Control state and stored banks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NUM_BANKS; b++) begin
        prev_bank_r[b] <= '1;
      end
      for (int e = 0; e < NUM_ENCODERS; e++) begin
        enc_lvl_r[e] <= '0;
        enc_flg_r[e] <= '0;
      end
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        prev_bank_r[bank_sel] <= in_val;
      end
      if (cmd.step && changed && enc_hit) begin
        enc_lvl_r[enc_sel] <= lvl_new;
        enc_flg_r[enc_sel] <= flg_new;
      end
      if (cmd.step && emit) begin
        pend_vld_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_vld_r <= 1'b0;
      end
      if (push_step || cmd.flush) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bank_r <= in_bank;
      val_r  <= in_val;
      diff_r <= prev_bank_r[bank_sel] ^ in_val;
    end
    if (cmd.step && emit) begin
      pend_bit_r  <= new_bit;
      pend_kind_r <= new_kind;
    end
    if (push_step || cmd.flush) begin
      out_bank_r <= bank_r;
      out_bit_r  <= pend_bit_r;
      out_kind_r <= pend_kind_r;
      out_last_r <= cmd.flush;
    end
  end

  assign out_valid = out_vld_r;
  assign out_bank  = out_bank_r;
  assign out_bit   = out_bit_r;
  assign out_kind  = out_kind_r;
  assign out_last  = out_last_r;

  `SBCE_ASSERT(a_cmd_exclusive, clk, rst_n, $onehot0({cmd.load, cmd.step, cmd.flush}), "more than one datapath command")
  `SBCE_NEVER(a_no_overwrite, clk, rst_n, (push_step || cmd.flush) && out_vld_r && !out_ready, "output register overwritten")
  `SBCE_ASSERT(a_flush_has_event, clk, rst_n, cmd.flush |-> pend_vld_r, "flush without pending event")

endmodule

>>> design/switch_bank_change_event_encoder_core.sv
// ---------------------------------------------------------------------------
// switch_bank_change_event_encoder_core: switch bank change and rotary events
// Each accepted in-range bank beat is handled in steps: accept, a scan of the
// eight bits (one bit per cycle through the shared encoder step, unless output
// back-pressure stalls the scan), then a flush of the last pending event.
// Reset: stored banks go to all ones, encoder levels and flags to zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module switch_bank_change_event_encoder_core
  import sbce_pkg::*;
#(
  parameter int NUM_BANKS    = DEF_NUM_BANKS,
  parameter int NUM_ENCODERS = DEF_NUM_ENCODERS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [3:0] bank_index, [11:4] bank_value, [15:12] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [3:0] event_bank, [6:4] event_bit, [7] zero
  output logic [1:0]  out_tuser,  // [1:0] event_kind
  output logic        out_tlast
);

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [BANK_W-1:0] ev_bank;
  logic [BIT_W-1:0]  ev_bit;
  kind_t             ev_kind;

  sbce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbce_dp #(
    .NUM_BANKS    (NUM_BANKS),
    .NUM_ENCODERS (NUM_ENCODERS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_bank   (in_tdata[3:0]),
    .in_val    (in_tdata[11:4]),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_bank  (ev_bank),
    .out_bit   (ev_bit),
    .out_kind  (ev_kind),
    .out_last  (out_tlast)
  );

  // Pack the result beat
  assign out_tdata = {1'b0, ev_bit, ev_bank};
  assign out_tuser = ev_kind;

endmodule

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: switch bank change-event encoder regression
// Drives scanned bank beats into the core and predicts every press and
// rotation event from a private copy of the stored banks and of the
// quadrature state. Each event beat is checked field by field, in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import sbce_pkg::*;

  localparam int NUM_BANKS    = DEF_NUM_BANKS;
  localparam int NUM_ENC      = DEF_NUM_ENCODERS;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_SCANS = 190;
  localparam int REPORT_MAX   = 10;

  // Rotary pairs: bank and low bit of each encoder, high bit is low + 1
  localparam logic [3:0] PAIR_BANK [NUM_ENC] = '{4'd2, 4'd4, 4'd4, 4'd6, 4'd7, 4'd10};
  localparam logic [2:0] PAIR_LOW  [NUM_ENC] = '{3'd5, 3'd4, 3'd0, 3'd4, 3'd4, 3'd2};
  // Gray order of {high, low} levels for one turn direction
  localparam logic [1:0] GRAY [4] = '{2'b00, 2'b01, 2'b11, 2'b10};

  typedef struct packed {
    logic [3:0] bank;
    logic [2:0] bpos;
    kind_t      kind;
    logic       last;
  } switch_event_t;

  // Event predictor and store of events still owed by the core
  class bank_event_board;
    logic [7:0]    stored [NUM_BANKS];
    logic [1:0]    levels [NUM_ENC];
    logic [1:0]    flags  [NUM_ENC];
    switch_event_t pending [$];
    int            errors;

    function new();
      foreach (stored[i]) stored[i] = 8'hFF;
      foreach (levels[i]) begin
        levels[i] = 2'b00;
        flags[i]  = 2'b00;
      end
      errors = 0;
    endfunction

    function int pair_of(logic [3:0] b, int bpos);
      for (int e = 0; e < NUM_ENC; e++) begin
        if (PAIR_BANK[e] == b && (bpos == PAIR_LOW[e] || bpos == PAIR_LOW[e] + 1))
          return e;
      end
      return -1;
    endfunction

    // One quadrature step; fired is set on a completed detent
    function kind_t quad_step(int e, logic h, logic l, output logic fired);
      logic th, tl, right, left;
      kind_t k;
      tl = levels[e][0];
      th = levels[e][1];
      right = flags[e][0];
      left = flags[e][1];
      fired = 1'b0;
      k = KIND_PRESS;
      if (h != l) begin
        if (h != th) begin
          th = h;
          right = 1'b1;
        end else if (l != tl) begin
          tl = l;
          left = 1'b1;
        end
      end else if (th != tl && (right || left)) begin
        if (right && th == h) begin
          fired = 1'b1;
          k = KIND_RIGHT;
          tl = l;
          right = 1'b0;
        end else if (left && tl == l) begin
          fired = 1'b1;
          k = KIND_LEFT;
          th = h;
          left = 1'b0;
        end else begin
          tl = l;
          th = h;
          right = 1'b0;
          left = 1'b0;
        end
      end
      levels[e] = {th, tl};
      flags[e] = {left, right};
      return k;
    endfunction

    // Predict the events of one accepted scan beat
    function void note_scan(logic [3:0] b, logic [7:0] v);
      logic [7:0]    diff;
      logic          fired;
      int            e;
      int            lo;
      kind_t         k;
      switch_event_t ev;
      switch_event_t batch [$];
      if (b >= NUM_BANKS) return;
      diff = stored[b] ^ v;
      for (int i = 0; i < 8; i++) begin
        if (diff[i]) begin
          e = pair_of(b, i);
          if (e >= 0) begin
            lo = PAIR_LOW[e];
            k = quad_step(e, v[lo + 1], v[lo], fired);
            if (fired) begin
              ev.bank = b;
              ev.bpos = (k == KIND_RIGHT) ? 3'(lo) : 3'(lo + 1);
              ev.kind = k;
              ev.last = 1'b0;
              batch.push_back(ev);
            end
          end else if (!v[i]) begin
            ev.bank = b;
            ev.bpos = 3'(i);
            ev.kind = KIND_PRESS;
            ev.last = 1'b0;
            batch.push_back(ev);
          end
        end
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) pending.push_back(batch[i]);
      stored[b] = v;
    endfunction

    // Compare one event beat with the oldest prediction
    function void check_event(logic [3:0] b, logic [2:0] bpos, kind_t k, logic last);
      switch_event_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected event: bank %0d bit %0d kind %0d last %0d",
                   b, bpos, k, last);
        return;
      end
      want = pending.pop_front();
      if (want.bank != b || want.bpos != bpos || want.kind != k || want.last != last) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("event mismatch bank/bit/kind/last: expected %0d/%0d/%0d/%0d",
                   want.bank, want.bpos, want.kind, want.last,
                   " got %0d/%0d/%0d/%0d", b, bpos, k, last);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [3:0] bank_index, [11:4] bank_value, [15:12] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [3:0] event_bank, [6:4] event_bit, [7] zero
  logic [1:0]  out_tuser;  // [1:0] event_kind
  logic        out_tlast;

  bank_event_board board = new();
  logic            calm;
  int              cycles;
  int              turn_dir [NUM_ENC];

  switch_bank_change_event_encoder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Throttle the event side at random, except in the calm stretch
  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 32);
  end

  // Check each event beat
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_event(out_tdata[3:0], out_tdata[6:4], kind_t'(out_tuser), out_tlast);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Send one scan beat, with an optional gap in front
  task automatic send_scan(input logic [3:0] b, input logic [7:0] v);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 32) gap = $urandom_range(1, 12);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {4'b0000, v, b};
    do @(posedge clk); while (!in_tready);
    board.note_scan(b, v);
  endtask

  task automatic drain_events();
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // Build one random scan: mostly encoder walks, some switch activity, some noise
  task automatic random_scan(output logic [3:0] b, output logic [7:0] v);
    int r;
    int e;
    int lo;
    int j;
    r = $urandom_range(99);
    if (r < 55) begin
      e = $urandom_range(0, NUM_ENC - 1);
      b = PAIR_BANK[e];
      lo = PAIR_LOW[e];
      v = board.stored[b];
      if ($urandom_range(9) == 0) turn_dir[e] = -turn_dir[e];
      if ($urandom_range(9) == 0) begin
        // both pair bits at once
        v[lo] = ~v[lo];
        v[lo + 1] = ~v[lo + 1];
      end else begin
        j = 0;
        for (int g = 0; g < 4; g++) if (GRAY[g] == {v[lo + 1], v[lo]}) j = g;
        j = (j + turn_dir[e]) & 3;
        {v[lo + 1], v[lo]} = GRAY[j];
      end
      if ($urandom_range(99) < 15) v[$urandom_range(0, 7)] ^= 1'b1;
    end else if (r < 80) begin
      b = 4'($urandom_range(0, NUM_BANKS - 1));
      v = board.stored[b];
      repeat ($urandom_range(1, 3)) v[$urandom_range(0, 7)] ^= 1'b1;
    end else begin
      b = 4'($urandom_range(0, 15));
      v = 8'($urandom);
    end
  endtask

  // Reset, directed scans, random scans, drain and verdict
  initial begin
    logic [11:0] directed [] = '{
      12'h0FF, 12'h000, 12'h0FF, 12'hC00, 12'hF00, 12'hB55,
      12'h2DF, 12'h29F, 12'h2BF, 12'h2FF, 12'h2DF, 12'h29F, 12'h2BF, 12'h2FF,
      12'h2BF, 12'h29F, 12'h2DF, 12'h2FF,
      12'h29F, 12'h2FF,
      12'h4CC, 12'h433, 12'h4FF, 12'hA00
    };
    logic [3:0] b;
    logic [7:0] v;
    int         counted;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    calm = 1'b0;
    cycles = 0;
    foreach (turn_dir[i]) turn_dir[i] = 1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) send_scan(directed[i][11:8], directed[i][7:0]);

    counted = 0;
    while (counted < RANDOM_SCANS) begin
      calm = (counted >= 60 && counted < 120);
      // hold off once until the core has emptied
      if (counted == 150) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        drain_events();
      end
      random_scan(b, v);
      send_scan(b, v);
      if (b < NUM_BANKS) counted++;
    end
    @(negedge clk);
    in_tvalid = 1'b0;

    drain_events();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
